@@ rtl/core/bpq_pkg.sv @@
// bitmap priority ready queue: shared field widths, opcode and status codes,
// result record. no dependencies; compiled before everything else.
`timescale 1ns / 1ps
`default_nettype none

package bpq_pkg;

    localparam int OP_W        = 2;
    localparam int THR_FIELD_W = 6;
    localparam int CPU_FIELD_W = 3;
    localparam int LVL_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_PICK = 2'd2,
        OP_PEEK = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_DUP        = 2'd2,
        ST_NOT_QUEUED = 2'd3
    } t_status;

    typedef struct packed {
        t_status                status;
        logic [THR_FIELD_W-1:0] thread;
        logic [LVL_W-1:0]       level;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/bpq_req_if.sv @@
// request channel of the ready queue: valid/ready plus one operation beat.
// depends on bpq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bpq_req_if import bpq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [OP_W-1:0]        opcode;
    logic [THR_FIELD_W-1:0] thread_number;
    logic [CPU_FIELD_W-1:0] cpu_number;
    logic [LVL_W-1:0]       thread_level;

    modport source(output valid, output opcode, output thread_number,
                   output cpu_number, output thread_level, input ready);
    modport sink(input valid, input opcode, input thread_number,
                 input cpu_number, input thread_level, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bpq_rsp_if.sv @@
// response channel of the ready queue: valid/ready plus one result beat.
// depends on bpq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bpq_rsp_if import bpq_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [THR_FIELD_W-1:0] chosen_thread;
    logic [LVL_W-1:0]       chosen_level;

    modport source(output valid, output status, output chosen_thread,
                   output chosen_level, input ready);
    modport sink(input valid, input status, input chosen_thread,
                 input chosen_level, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bpq_ram.sv @@
// generic single-port synchronous ram, one access per cycle, registered read.
// no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bpq_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/bpq_ffs.sv @@
// find-first-set: lowest set bit of a vector and whether any bit is set.
// no dependencies; used for the word summary and for one occupancy word.
`timescale 1ns / 1ps
`default_nettype none

module bpq_ffs #(
    parameter int  WIDTH = 32,
    localparam int IW    = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
    input  wire logic [WIDTH-1:0] i_bits,
    output logic                  o_found,
    output logic      [IW-1:0]    o_index
);

    always_comb begin
        o_found = |i_bits;
        o_index = '0;
        // scan down so the lowest set bit wins
        for (int i = WIDTH - 1; i >= 0; i--) begin
            if (i_bits[i]) begin
                o_index = IW'(i);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bitmap_priority_ready_queue.sv @@
// per-cpu ready queue with bitmap-indexed priority levels, top level.
// depends on bpq_pkg, bpq_req_if, bpq_rsp_if, bpq_ram and bpq_ffs.
//
//   port    dir  beat contents
//   i_req   in   opcode, thread_number, cpu_number, thread_level
//   o_rsp   out  status, chosen_thread, chosen_level
//
// one operation at a time, in states set by the registered reads of the
// single-port list rams: enqueue ENQ_RD/WR, dequeue UL_RD/SLOT/WR,
// peek FIND_WORD/HEAD/DONE, pick adds UL_SLOT/WR; rejected or empty: DONE.
// a finished result sits in the output register; the next beat is taken
// while it waits, and the block stalls only if a second result is ready.
// reset clears the queued flags and the per-word nonzero flags;
// the rams need no clearing pass since an entry is always written before use.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_priority_ready_queue import bpq_pkg::*; #(
    parameter int NUM_CPUS    = 2,
    parameter int NUM_THREADS = 64,
    parameter int LEVEL_WORDS = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpq_req_if.sink    i_req,
    bpq_rsp_if.source  o_rsp
);

    localparam int LEVELS_PER_CPU = LEVEL_WORDS * WORD_BITS;
    localparam int LEVEL_SLOTS    = NUM_CPUS * LEVELS_PER_CPU;
    localparam int WORD_SLOTS     = NUM_CPUS * LEVEL_WORDS;
    localparam int TW             = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
    localparam int CW             = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int SW             = (LEVEL_SLOTS > 1) ? $clog2(LEVEL_SLOTS) : 1;
    localparam int WW             = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
    localparam int LWI            = (LEVEL_WORDS > 1) ? $clog2(LEVEL_WORDS) : 1;
    localparam int REC_W          = LVL_W + CW;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_ENQ_RD    = 10'b00_0000_0010,
        S_ENQ_WR    = 10'b00_0000_0100,
        S_UL_RD     = 10'b00_0000_1000,
        S_UL_SLOT   = 10'b00_0001_0000,
        S_UL_WR     = 10'b00_0010_0000,
        S_FIND_WORD = 10'b00_0100_0000,
        S_FIND_HEAD = 10'b00_1000_0000,
        S_FIND_DONE = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } t_state;

    function automatic logic [TW-1:0] f_thr(input logic [TW-1:0] x);
        return (int'(x) < NUM_THREADS) ? x : '0;
    endfunction

    function automatic logic [SW-1:0] f_slot(input logic [CW-1:0] cpu,
                                             input logic [LVL_W-1:0] lvl);
        return SW'(int'(cpu) * LEVELS_PER_CPU + int'(lvl));
    endfunction

    function automatic logic [WW-1:0] f_word(input logic [CW-1:0] cpu,
                                             input logic [LVL_W-1:0] lvl);
        return WW'(int'(cpu) * LEVEL_WORDS + int'(lvl >> BIT_W));
    endfunction

    // control and flags
    t_state                  r_state, n_state;
    logic [NUM_THREADS-1:0]  r_queued;
    logic [WORD_SLOTS-1:0]   r_nz;
    logic                    r_out_valid;

    // operation payload
    t_op                     r_op;
    logic [TW-1:0]           r_thr;
    logic [CW-1:0]           r_cpu;
    logic [LVL_W-1:0]        r_lvl;
    logic [LWI-1:0]          r_widx;
    logic [TW-1:0]           r_nx;
    logic [TW-1:0]           r_pv;
    t_result                 r_res;
    t_result                 r_out;

    // input decode
    t_op                     in_op;
    logic [CW-1:0]           in_cpu;
    logic [LVL_W-1:0]        in_lvl;
    logic [TW-1:0]           in_thr;
    logic                    in_range;
    logic                    in_queued;
    logic                    in_fire;
    logic [LEVEL_WORDS-1:0]  cpu_nz;
    logic                    nz_any;
    logic [LWI-1:0]          nz_idx;
    t_status                 acc_status;

    // ram ports
    logic                    occ_we, head_we, tail_we, next_we, prev_we, rec_we;
    logic [WW-1:0]           occ_addr;
    logic [SW-1:0]           head_addr, tail_addr;
    logic [TW-1:0]           next_addr, prev_addr, rec_addr;
    logic [WORD_BITS-1:0]    occ_wd, occ_rd;
    logic [TW-1:0]           head_wd, head_rd, tail_wd, tail_rd;
    logic [TW-1:0]           next_wd, next_rd, prev_wd, prev_rd;
    logic [REC_W-1:0]        rec_wd, rec_rd;

    // datapath helpers
    logic [SW-1:0]           cur_slot;
    logic [WW-1:0]           cur_word;
    logic [WORD_BITS-1:0]    cur_mask;
    logic [WORD_BITS-1:0]    occ_now;
    logic                    busy;
    logic [CW-1:0]           rec_cpu;
    logic [LVL_W-1:0]        rec_lvl;
    logic                    bit_found;
    logic [BIT_W-1:0]        bit_idx;
    logic [LVL_W-1:0]        found_lvl;
    logic [TW-1:0]           head_thr;
    logic                    is_head, is_tail;
    logic                    out_load;

    // ---------------------------------------------------------------- rams
    bpq_ram #(.WIDTH(WORD_BITS), .DEPTH(WORD_SLOTS)) u_occ_ram (
        .i_clk(i_clk), .i_we(occ_we), .i_addr(occ_addr), .i_wdata(occ_wd),
        .o_rdata(occ_rd)
    );
    bpq_ram #(.WIDTH(TW), .DEPTH(LEVEL_SLOTS)) u_head_ram (
        .i_clk(i_clk), .i_we(head_we), .i_addr(head_addr), .i_wdata(head_wd),
        .o_rdata(head_rd)
    );
    bpq_ram #(.WIDTH(TW), .DEPTH(LEVEL_SLOTS)) u_tail_ram (
        .i_clk(i_clk), .i_we(tail_we), .i_addr(tail_addr), .i_wdata(tail_wd),
        .o_rdata(tail_rd)
    );
    bpq_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_next_ram (
        .i_clk(i_clk), .i_we(next_we), .i_addr(next_addr), .i_wdata(next_wd),
        .o_rdata(next_rd)
    );
    bpq_ram #(.WIDTH(TW), .DEPTH(NUM_THREADS)) u_prev_ram (
        .i_clk(i_clk), .i_we(prev_we), .i_addr(prev_addr), .i_wdata(prev_wd),
        .o_rdata(prev_rd)
    );
    bpq_ram #(.WIDTH(REC_W), .DEPTH(NUM_THREADS)) u_rec_ram (
        .i_clk(i_clk), .i_we(rec_we), .i_addr(rec_addr), .i_wdata(rec_wd),
        .o_rdata(rec_rd)
    );

    // ------------------------------------------------------- input decode
    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign in_op       = t_op'(i_req.opcode);
    assign in_cpu      = (int'(i_req.cpu_number) < NUM_CPUS) ? CW'(i_req.cpu_number) : '0;
    assign in_lvl      = (int'(i_req.thread_level) >= LEVELS_PER_CPU) ?
                         LVL_W'(LEVELS_PER_CPU - 1) : i_req.thread_level;
    assign in_range    = int'(i_req.thread_number) < NUM_THREADS;
    assign in_thr      = TW'(i_req.thread_number);
    assign in_queued   = in_range && r_queued[in_thr];

    always_comb begin
        for (int i = 0; i < LEVEL_WORDS; i++) begin
            cpu_nz[i] = r_nz[WW'(int'(in_cpu) * LEVEL_WORDS + i)];
        end
    end

    bpq_ffs #(.WIDTH(LEVEL_WORDS)) u_word_ffs (
        .i_bits(cpu_nz), .o_found(nz_any), .o_index(nz_idx)
    );

    // --------------------------------------------------- datapath helpers
    assign cur_slot  = f_slot(r_cpu, r_lvl);
    assign cur_word  = f_word(r_cpu, r_lvl);
    assign cur_mask  = WORD_BITS'(1) << r_lvl[BIT_W-1:0];
    // a word whose nonzero flag is clear reads as empty, whatever the ram holds
    assign occ_now   = r_nz[cur_word] ? occ_rd : '0;
    assign busy      = |(occ_now & cur_mask);
    assign rec_cpu   = rec_rd[CW-1:0];
    assign rec_lvl   = rec_rd[REC_W-1 -: LVL_W];
    assign found_lvl = LVL_W'((int'(r_widx) << BIT_W) + int'(bit_idx));
    assign head_thr  = f_thr(head_rd);
    assign is_head   = (head_rd == r_thr);
    assign is_tail   = (tail_rd == r_thr);
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    bpq_ffs #(.WIDTH(WORD_BITS)) u_bit_ffs (
        .i_bits(occ_rd), .o_found(bit_found), .o_index(bit_idx)
    );

    always_comb begin
        acc_status = ST_DONE;
        n_state    = r_state;
        unique case (r_state)
            S_IDLE: begin
                case (in_op) inside
                    OP_ENQ: begin
                        if (!in_range) begin
                            acc_status = ST_NOT_QUEUED;
                        end else if (in_queued) begin
                            acc_status = ST_DUP;
                        end
                    end
                    OP_DEQ: begin
                        if (!in_queued) begin
                            acc_status = ST_NOT_QUEUED;
                        end
                    end
                    OP_PICK, OP_PEEK: begin
                        if (!nz_any) begin
                            acc_status = ST_EMPTY;
                        end
                    end
                endcase
                if (in_fire) begin
                    if (acc_status != ST_DONE) begin
                        n_state = S_DONE;
                    end else if (in_op == OP_ENQ) begin
                        n_state = S_ENQ_RD;
                    end else if (in_op == OP_DEQ) begin
                        n_state = S_UL_RD;
                    end else begin
                        n_state = S_FIND_WORD;
                    end
                end
            end
            S_ENQ_RD:    n_state = S_ENQ_WR;
            S_ENQ_WR:    n_state = S_DONE;
            S_UL_RD:     n_state = S_UL_SLOT;
            S_UL_SLOT:   n_state = S_UL_WR;
            S_UL_WR:     n_state = S_DONE;
            S_FIND_WORD: n_state = S_FIND_HEAD;
            S_FIND_HEAD: n_state = S_FIND_DONE;
            S_FIND_DONE: n_state = (r_op == OP_PICK) ? S_UL_SLOT : S_DONE;
            S_DONE:      n_state = out_load ? S_IDLE : S_DONE;
            default:     n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------- ram control
    always_comb begin
        occ_we    = 1'b0;  occ_addr  = cur_word;  occ_wd  = '0;
        head_we   = 1'b0;  head_addr = cur_slot;  head_wd = r_thr;
        tail_we   = 1'b0;  tail_addr = cur_slot;  tail_wd = r_thr;
        next_we   = 1'b0;  next_addr = r_thr;     next_wd = r_thr;
        prev_we   = 1'b0;  prev_addr = r_thr;     prev_wd = r_thr;
        rec_we    = 1'b0;  rec_addr  = r_thr;     rec_wd  = {r_lvl, r_cpu};
        unique case (r_state)
            S_ENQ_WR: begin
                if (busy) begin
                    // append behind the current tail
                    next_we   = 1'b1;
                    next_addr = f_thr(tail_rd);
                    next_wd   = r_thr;
                    prev_we   = 1'b1;
                    prev_addr = r_thr;
                    prev_wd   = f_thr(tail_rd);
                end else begin
                    head_we = 1'b1;
                    occ_we  = 1'b1;
                    occ_wd  = occ_now | cur_mask;
                end
                tail_we = 1'b1;
                rec_we  = 1'b1;
            end
            S_UL_SLOT: begin
                head_addr = f_slot(rec_cpu, rec_lvl);
                tail_addr = f_slot(rec_cpu, rec_lvl);
                occ_addr  = f_word(rec_cpu, rec_lvl);
            end
            S_UL_WR: begin
                if (is_head && is_tail) begin
                    occ_we = 1'b1;
                    occ_wd = occ_now & ~cur_mask;
                end else if (is_head) begin
                    head_we = 1'b1;
                    head_wd = r_nx;
                end else if (is_tail) begin
                    tail_we = 1'b1;
                    tail_wd = r_pv;
                end else begin
                    next_we   = 1'b1;
                    next_addr = r_pv;
                    next_wd   = r_nx;
                    prev_we   = 1'b1;
                    prev_addr = r_nx;
                    prev_wd   = r_pv;
                end
            end
            S_FIND_WORD: begin
                occ_addr = WW'(int'(r_cpu) * LEVEL_WORDS + int'(r_widx));
            end
            S_FIND_HEAD: begin
                head_addr = f_slot(r_cpu, found_lvl);
            end
            S_FIND_DONE: begin
                // pick falls into the unlink path with the head thread
                rec_addr  = head_thr;
                next_addr = head_thr;
                prev_addr = head_thr;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------ control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_queued    <= '0;
            r_nz        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ENQ_WR) begin
                r_queued[r_thr] <= 1'b1;
                if (!busy) begin
                    r_nz[cur_word] <= 1'b1;
                end
            end
            if (r_state == S_UL_WR) begin
                r_queued[r_thr] <= 1'b0;
                if (is_head && is_tail) begin
                    r_nz[cur_word] <= |(occ_now & ~cur_mask);
                end
            end
        end
    end

    // ------------------------------------------------ payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= in_op;
            r_thr  <= in_thr;
            r_cpu  <= in_cpu;
            r_lvl  <= in_lvl;
            r_widx <= nz_idx;
            r_res  <= '{status: acc_status, thread: '0, level: '0};
        end
        if (r_state == S_UL_SLOT) begin
            r_cpu <= rec_cpu;
            r_lvl <= rec_lvl;
            r_nx  <= f_thr(next_rd);
            r_pv  <= f_thr(prev_rd);
        end
        if (r_state == S_FIND_HEAD) begin
            r_lvl       <= found_lvl;
            r_res.level <= found_lvl;
        end
        if (r_state == S_FIND_DONE) begin
            r_res.thread <= THR_FIELD_W'(head_thr);
            r_thr        <= head_thr;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.chosen_thread = r_out.thread;
    assign o_rsp.chosen_level  = r_out.level;

    // ---------------------------------------------------------- checks
    a_enq_not_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ENQ_WR |-> !r_queued[r_thr])
        else $error("enqueue write on a thread already queued");

    a_unlink_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UL_WR |-> r_queued[r_thr])
        else $error("unlink of a thread that is not queued");

    a_word_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIND_HEAD |-> bit_found)
        else $error("nonzero flag set on an empty occupancy word");

    a_head_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIND_DONE |-> r_queued[head_thr])
        else $error("head of an occupied level is not queued");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_rsp.ready) |=> r_state == S_DONE)
        else $error("result overwrote an unsent beat");

endmodule

`default_nettype wire

@@ bench/bpq_checker.sv @@
// ready queue checker: watches the request and response channels, keeps its own
// copy of the per-cpu level lists and compares every response beat in order.
// depends on bpq_pkg, bpq_req_if and bpq_rsp_if.
`timescale 1ns / 1ps

module bpq_checker import bpq_pkg::*; #(
    parameter int NUM_CPUS    = 2,
    parameter int NUM_THREADS = 64,
    parameter int LEVEL_WORDS = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bpq_req_if        i_req,
    bpq_rsp_if        i_rsp,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int LEVELS     = LEVEL_WORDS * WORD_BITS;
    localparam int SLOTS      = NUM_CPUS * LEVELS;
    localparam int WORDS      = NUM_CPUS * LEVEL_WORDS;

    logic [WORD_BITS-1:0] occ_bits [WORDS];
    logic [7:0]           head_thr [SLOTS];
    logic [7:0]           tail_thr [SLOTS];
    logic [7:0]           next_thr [NUM_THREADS];
    logic [7:0]           prev_thr [NUM_THREADS];
    bit                   queued   [NUM_THREADS];
    logic [7:0]           home_lvl [NUM_THREADS];
    logic [2:0]           home_cpu [NUM_THREADS];

    t_result answer_q[$];
    int      fails;

    function automatic int thr_ok(int x);
        return (x < NUM_THREADS) ? x : 0;
    endfunction

    function automatic int slot_idx(int cpu, int lvl);
        int s = cpu * LEVELS + lvl;
        return (s < SLOTS) ? s : 0;
    endfunction

    function automatic int word_idx(int cpu, int lvl);
        int w = cpu * LEVEL_WORDS + (lvl >> BIT_W);
        return (w < WORDS) ? w : 0;
    endfunction

    function automatic bit level_set(int cpu, int lvl);
        return occ_bits[word_idx(cpu, lvl)][lvl & (WORD_BITS - 1)];
    endfunction

    function automatic bit lowest_level(int cpu, output int lvl);
        lvl = 0;
        for (int l = 0; l < LEVELS; l++) begin
            if (level_set(cpu, l)) begin
                lvl = l;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // only the list ends or the neighbor links get patched, never both
    function automatic void unlink_thread(int t);
        int  cpu      = int'(home_cpu[t]);
        int  lvl      = int'(home_lvl[t]);
        int  s        = slot_idx(cpu, lvl);
        int  nx       = thr_ok(int'(next_thr[t]));
        int  pv       = thr_ok(int'(prev_thr[t]));
        bit  at_head  = (int'(head_thr[s]) == t);
        bit  at_tail  = (int'(tail_thr[s]) == t);
        if (at_head && at_tail) begin
            occ_bits[word_idx(cpu, lvl)][lvl & (WORD_BITS - 1)] = 1'b0;
        end else if (at_head) begin
            head_thr[s] = 8'(nx);
        end else if (at_tail) begin
            tail_thr[s] = 8'(pv);
        end else begin
            next_thr[pv] = 8'(nx);
            prev_thr[nx] = 8'(pv);
        end
        queued[t] = 1'b0;
    endfunction

    function automatic t_result apply_sched_op(t_op op, int t, int cpu_in, int lvl_in);
        t_result r;
        int      cpu = cpu_in;
        int      lvl = lvl_in;
        int      s;
        int      tl;
        int      found;
        int      pick;
        r.status = ST_DONE;
        r.thread = '0;
        r.level  = '0;
        if (cpu >= NUM_CPUS) cpu = 0;
        if (lvl >= LEVELS) lvl = LEVELS - 1;
        case (op)
            OP_ENQ: begin
                if (t >= NUM_THREADS) begin
                    r.status = ST_NOT_QUEUED;
                end else if (queued[t]) begin
                    r.status = ST_DUP;
                end else begin
                    s = slot_idx(cpu, lvl);
                    if (level_set(cpu, lvl)) begin
                        tl = thr_ok(int'(tail_thr[s]));
                        next_thr[tl] = 8'(t);
                        prev_thr[t]  = 8'(tl);
                    end else begin
                        head_thr[s] = 8'(t);
                        occ_bits[word_idx(cpu, lvl)][lvl & (WORD_BITS - 1)] = 1'b1;
                    end
                    tail_thr[s] = 8'(t);
                    queued[t]   = 1'b1;
                    home_lvl[t] = 8'(lvl);
                    home_cpu[t] = 3'(cpu);
                end
            end
            OP_DEQ: begin
                if (t >= NUM_THREADS || !queued[t]) r.status = ST_NOT_QUEUED;
                else unlink_thread(t);
            end
            default: begin
                if (!lowest_level(cpu, found)) begin
                    r.status = ST_EMPTY;
                end else begin
                    pick     = thr_ok(int'(head_thr[slot_idx(cpu, found)]));
                    r.thread = THR_FIELD_W'(pick);
                    r.level  = LVL_W'(found);
                    if (op == OP_PICK) unlink_thread(pick);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (occ_bits[i]) occ_bits[i] = '0;
            foreach (head_thr[i]) begin
                head_thr[i] = '0;
                tail_thr[i] = '0;
            end
            foreach (next_thr[i]) begin
                next_thr[i] = '0;
                prev_thr[i] = '0;
                queued[i]   = 1'b0;
                home_lvl[i] = '0;
                home_cpu[i] = '0;
            end
            answer_q.delete();
            fails = 0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                answer_q.push_back(apply_sched_op(t_op'(i_req.opcode),
                                                  int'(i_req.thread_number),
                                                  int'(i_req.cpu_number),
                                                  int'(i_req.thread_level)));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (answer_q.size() == 0) begin
                    fails++;
                    $display({"%0t: unexpected result beat: expected none, ",
                              "got status %0d thread %0d level %0d"},
                             $time, i_rsp.status, i_rsp.chosen_thread, i_rsp.chosen_level);
                end else begin
                    want = answer_q.pop_front();
                    if (i_rsp.status !== want.status || i_rsp.chosen_thread !== want.thread ||
                        i_rsp.chosen_level !== want.level) begin
                        fails++;
                        $display({"%0t: result mismatch: expected status %0d thread %0d ",
                                  "level %0d, got status %0d thread %0d level %0d"},
                                 $time, want.status, want.thread, want.level,
                                 i_rsp.status, i_rsp.chosen_thread, i_rsp.chosen_level);
                    end
                end
            end
        end
        o_pending    <= answer_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ bench/tb_top.sv @@
// top of the ready queue bench: clock, reset, request stimulus, response stalls,
// watchdog and verdict. depends on bpq_pkg, both channel interfaces, bpq_checker
// and the bitmap_priority_ready_queue rtl.
`timescale 1ns / 1ps

module tb_top;
    import bpq_pkg::*;

    localparam int NUM_CPUS       = 2;
    localparam int NUM_THREADS    = 64;
    localparam int LEVEL_WORDS    = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_ITEMS    = 190;
    localparam int NUM_PHASES     = 5;
    localparam int SRC_IDLE   [NUM_PHASES] = '{0, 57, 0, 30, 0};
    localparam int SINK_STALL [NUM_PHASES] = '{0, 0, 57, 30, 0};
    localparam int BOUNDARY_LVLS [4] = '{0, 31, 32, 255};

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   quiet_cycles;
    bit   drain_mode;

    bpq_req_if req_if();
    bpq_rsp_if rsp_if();

    bitmap_priority_ready_queue #(
        .NUM_CPUS    (NUM_CPUS),
        .NUM_THREADS (NUM_THREADS),
        .LEVEL_WORDS (LEVEL_WORDS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    bpq_checker #(
        .NUM_CPUS    (NUM_CPUS),
        .NUM_THREADS (NUM_THREADS),
        .LEVEL_WORDS (LEVEL_WORDS)
    ) u_sched_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) rsp_if.ready <= 1'b0;
        else rsp_if.ready <= (int'($urandom_range(99, 0)) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("bitmap_priority_ready_queue test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue(input t_op op, input int thr, input int cpu, input int lvl);
        while (int'($urandom_range(99, 0)) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.opcode        <= op;
        req_if.thread_number <= THR_FIELD_W'(thr);
        req_if.cpu_number    <= CPU_FIELD_W'(cpu);
        req_if.thread_level  <= LVL_W'(lvl);
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // hold the request side until every outstanding answer has come back
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic random_op();
        int   roll;
        int   thr;
        int   lvl;
        t_op  op;
        if (int'($urandom_range(99, 0)) < 3) drain_mode = !drain_mode;
        roll = int'($urandom_range(99, 0));
        if (drain_mode)
            op = (roll < 70) ? OP_PICK : (roll < 80) ? OP_PEEK : OP_DEQ;
        else
            op = (roll < 40) ? OP_ENQ : (roll < 65) ? OP_DEQ : (roll < 82) ? OP_PICK : OP_PEEK;
        // a small thread pool keeps duplicates and real dequeues frequent
        if (int'($urandom_range(99, 0)) < 70) thr = int'($urandom_range(15, 0));
        else thr = int'($urandom_range(63, 0));
        case ($urandom_range(4, 0))
            0, 1, 2: lvl = int'($urandom_range(3, 0));
            3:       lvl = int'($urandom_range(255, 0));
            default: lvl = BOUNDARY_LVLS[$urandom_range(3, 0)];
        endcase
        issue(op, thr, int'($urandom_range(7, 0)), lvl);
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.opcode        = '0;
        req_if.thread_number = '0;
        req_if.cpu_number    = '0;
        req_if.thread_level  = '0;
        src_idle_pct         = 0;
        sink_stall_pct       = 0;
        drain_mode           = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queues, then one cpu's fifo built and taken apart from every position
        issue(OP_PEEK, 0, 0, 0);
        issue(OP_PICK, 63, 1, 255);
        issue(OP_DEQ, 63, 0, 0);
        issue(OP_ENQ, 0, 0, 255);
        issue(OP_ENQ, 63, 7, 0);
        issue(OP_ENQ, 5, 1, 0);
        issue(OP_ENQ, 5, 0, 17);
        issue(OP_ENQ, 10, 0, 0);
        issue(OP_ENQ, 11, 0, 0);
        issue(OP_ENQ, 12, 0, 0);
        issue(OP_PEEK, 0, 0, 0);
        issue(OP_DEQ, 10, 0, 0);
        issue(OP_DEQ, 12, 0, 0);
        issue(OP_PICK, 0, 2, 0);
        issue(OP_PICK, 0, 0, 0);
        issue(OP_PICK, 0, 0, 0);
        issue(OP_PICK, 0, 0, 0);
        issue(OP_PEEK, 0, 1, 0);
        issue(OP_DEQ, 5, 0, 0);
        issue(OP_PEEK, 0, 1, 0);
        issue(OP_ENQ, 42, 1, 31);
        issue(OP_ENQ, 43, 1, 32);
        issue(OP_PEEK, 0, 1, 0);
        issue(OP_DEQ, 42, 0, 0);
        issue(OP_PICK, 0, 1, 0);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            src_idle_pct   <= SRC_IDLE[p];
            sink_stall_pct <= SINK_STALL[p];
            repeat (PHASE_ITEMS) random_op();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("bitmap_priority_ready_queue test passed");
        end else begin
            $display("bitmap_priority_ready_queue test failed");
        end
        $finish;
    end

endmodule
